// ===== hdl/tpbe_pkg.sv =====
`timescale 1ns / 1ps

package tpbe_pkg;

    // Request operation codes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FAST_MODE  = 2'd0,
        CFG_HIGH_LEVEL = 2'd1,
        CFG_LOW_LEVEL  = 2'd2
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int SAMPLE_W   = 8;
    localparam int BYTE_W     = 8;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] HIGH_LEVEL_RST = 8'he0;
    localparam logic [SAMPLE_W-1:0] LOW_LEVEL_RST  = 8'h20;

    // Pulse timing: each pulse is a high half then a low half
    localparam logic [3:0] PULSE_HALF       = 4'd7;
    localparam logic [3:0] PULSE_LEN        = 4'd14;
    localparam logic [3:0] ONE_PULSES       = 4'd9;
    localparam logic [3:0] ONE_PULSES_FAST  = 4'd7;
    localparam logic [3:0] ZERO_PULSES      = 4'd4;
    localparam logic [3:0] ZERO_PULSES_FAST = 4'd3;
    localparam logic [5:0] GAP_LEN          = 6'd60;
    localparam logic [5:0] GAP_LEN_FAST     = 6'd20;
    localparam logic [2:0] LAST_BIT         = 3'd7;

    // One result item
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                sample_valid;
        logic                accepted;
        logic                byte_done;
        logic                busy_res;
    } result_t;

endpackage

// ===== hdl/tape_pulse_bit_encoder.sv =====
`timescale 1ns / 1ps

// Result: a request accepted at a clock edge has its result in the result register on m_* from that edge.
// Throughput: one request per cycle while m_ready holds; the encoder counters and the result register update together.
// s_ready stays high while the result register is empty or being drained at the same edge.
// Reset (aresetn low, synchronous): encoder idle, counters cleared, result register empty,
// fast_mode 0, high_level 0xe0, low_level 0x20.
module tape_pulse_bit_encoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic [tpbe_pkg::BYTE_W-1:0]        s_data_byte,
    // Result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tpbe_pkg::SAMPLE_W-1:0]      m_sample,
    output logic                               m_sample_valid,
    output logic                               m_accepted,
    output logic                               m_byte_done,
    output logic                               m_busy_res,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [tpbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tpbe_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    import tpbe_pkg::*;

    // Configuration registers
    logic                fast_mode_reg;
    logic [SAMPLE_W-1:0] high_level_reg;
    logic [SAMPLE_W-1:0] low_level_reg;

    // Encoder state
    logic [BYTE_W-1:0] shift_byte_reg, shift_byte_next;
    logic [2:0]        bit_index_reg, bit_index_next;
    logic [3:0]        pulse_index_reg, pulse_index_next;
    logic [3:0]        phase_index_reg, phase_index_next;
    logic [5:0]        gap_index_reg, gap_index_next;
    logic              in_gap_reg, in_gap_next;
    logic              sending_reg, sending_next;

    // Result register
    logic    out_valid_reg;
    result_t result_reg, result_next;

    logic       accept;
    logic [3:0] pulses;
    logic [5:0] gap_len;
    logic [3:0] phase_inc;
    logic [3:0] pulse_inc;
    logic [5:0] gap_inc;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_mode_reg  <= 1'b0;
            high_level_reg <= HIGH_LEVEL_RST;
            low_level_reg  <= LOW_LEVEL_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FAST_MODE:  fast_mode_reg  <= cfg_wdata[0];
                CFG_HIGH_LEVEL: high_level_reg <= cfg_wdata;
                CFG_LOW_LEVEL:  low_level_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Train and gap lengths for the current bit and mode
    always_comb begin
        if (shift_byte_reg[BYTE_W-1]) begin
            pulses = fast_mode_reg ? ONE_PULSES_FAST : ONE_PULSES;
        end else begin
            pulses = fast_mode_reg ? ZERO_PULSES_FAST : ZERO_PULSES;
        end
        gap_len   = fast_mode_reg ? GAP_LEN_FAST : GAP_LEN;
        phase_inc = phase_index_reg + 4'd1;
        pulse_inc = pulse_index_reg + 4'd1;
        gap_inc   = gap_index_reg + 6'd1;
    end

    // Advance the encoder and build the result for one request
    always_comb begin
        shift_byte_next  = shift_byte_reg;
        bit_index_next   = bit_index_reg;
        pulse_index_next = pulse_index_reg;
        phase_index_next = phase_index_reg;
        gap_index_next   = gap_index_reg;
        in_gap_next      = in_gap_reg;
        sending_next     = sending_reg;
        result_next      = '0;

        case (s_operation)
            OP_LOAD: begin
                if (!sending_reg) begin
                    shift_byte_next      = s_data_byte;
                    bit_index_next       = '0;
                    pulse_index_next     = '0;
                    phase_index_next     = '0;
                    gap_index_next       = '0;
                    in_gap_next          = 1'b0;
                    sending_next         = 1'b1;
                    result_next.accepted = 1'b1;
                end
            end
            OP_TICK: begin
                result_next.sample_valid = 1'b1;
                if (!sending_reg) begin
                    result_next.sample = low_level_reg;
                end else if (!in_gap_reg) begin
                    result_next.sample = (phase_index_reg < PULSE_HALF) ? high_level_reg
                                                                        : low_level_reg;
                    phase_index_next = phase_inc;
                    if (phase_inc >= PULSE_LEN) begin
                        phase_index_next = '0;
                        pulse_index_next = pulse_inc;
                        if (pulse_inc >= pulses) begin
                            pulse_index_next = '0;
                            in_gap_next      = 1'b1;
                            gap_index_next   = '0;
                        end
                    end
                end else begin
                    result_next.sample = low_level_reg;
                    gap_index_next     = gap_inc;
                    if (gap_inc >= gap_len) begin
                        gap_index_next = '0;
                        in_gap_next    = 1'b0;
                        if (bit_index_reg >= LAST_BIT) begin
                            bit_index_next        = '0;
                            sending_next          = 1'b0;
                            result_next.byte_done = 1'b1;
                        end else begin
                            bit_index_next  = bit_index_reg + 3'd1;
                            shift_byte_next = {shift_byte_reg[BYTE_W-2:0], 1'b0};
                        end
                    end
                end
            end
            default: ;
        endcase

        result_next.busy_res = sending_next;
    end

    // Update encoder state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_byte_reg  <= '0;
            bit_index_reg   <= '0;
            pulse_index_reg <= '0;
            phase_index_reg <= '0;
            gap_index_reg   <= '0;
            in_gap_reg      <= 1'b0;
            sending_reg     <= 1'b0;
        end else if (accept) begin
            shift_byte_reg  <= shift_byte_next;
            bit_index_reg   <= bit_index_next;
            pulse_index_reg <= pulse_index_next;
            phase_index_reg <= phase_index_next;
            gap_index_reg   <= gap_index_next;
            in_gap_reg      <= in_gap_next;
            sending_reg     <= sending_next;
        end
    end

    // Hold the result until taken; load a new one on accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_sample       = result_reg.sample;
    assign m_sample_valid = result_reg.sample_valid;
    assign m_accepted     = result_reg.accepted;
    assign m_byte_done    = result_reg.byte_done;
    assign m_busy_res     = result_reg.busy_res;

`ifndef SYNTH
    // A finished byte leaves the encoder idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_byte_done) |-> (!m_busy_res && m_sample_valid))
        else $error("byte_done result reports busy");

    // A taken load is never a sample and always starts a byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_accepted) |-> (!m_sample_valid && m_busy_res))
        else $error("accepted load result malformed");

    // The gap phase only exists while a byte is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_gap_reg |-> sending_reg)
        else $error("gap phase while idle");

    // Phase counter wraps before reaching the pulse length
    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_index_reg < PULSE_LEN)
        else $error("phase counter overran pulse length");

    // A load into an idle encoder starts sending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_operation == OP_LOAD) && !sending_reg) |=> sending_reg)
        else $error("load did not start the encoder");
`endif

endmodule
